// ===== rtl/lls_pkg.sv =====
// Shared types, constants and lexer step functions for the logical line scanner.
`timescale 1ns / 1ps
package lls_pkg;

  localparam int unsigned SOURCE_BYTES = 16777216;
  localparam int unsigned NEST_LIMIT   = 65535;
  localparam int unsigned INDENT_TAB   = 4;

  localparam int POS_W   = 25;
  localparam int OFF_W   = 24;
  localparam int LINE_W  = 25;
  localparam int LEN_W   = 25;
  localparam int IND_W   = 16;
  localparam int DEPTH_W = 16;
  localparam int ST_W    = 3;
  localparam int TDATA_W = 96;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [POS_W-1:0]   POS_TOP   = POS_W'(SOURCE_BYTES);
  localparam logic [OFF_W-1:0]   OFF_TOP   = OFF_W'(SOURCE_BYTES - 1);
  localparam logic [LINE_W-1:0]  LINE_TOP  = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(NEST_LIMIT);
  localparam logic [IND_W-1:0]   IND_TOP   = '1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_LINECMT,
    MODE_QUOTE,
    MODE_BLOCK
  } lex_mode_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_OPEN,
    PEND_BSL,
    PEND_BSLCR
  } pend_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_QUOTE   = 3'd1,
    ST_PAREN   = 3'd2,
    ST_BRACKET = 3'd3,
    ST_BRACE   = 3'd4,
    ST_BLOCK   = 3'd5
  } status_t;

  typedef struct packed {
    lex_mode_t          mode;
    logic [7:0]         quote_char;
    logic               esc;
    pend_t              pend;
    logic [DEPTH_W-1:0] paren;
    logic [DEPTH_W-1:0] bracket;
    logic [DEPTH_W-1:0] brace;
    logic [LINE_W-1:0]  line_cnt;
    logic [LINE_W-1:0]  node_line;
    logic [POS_W-1:0]   node_off;
    logic [IND_W-1:0]   indent;
    logic               seen;
    logic               hash;
    logic               frozen;
  } lex_state_t;

  typedef struct packed {
    lex_state_t state;
    logic       node_v;
  } lex_step_t;

  typedef struct packed {
    logic              node_v;
    logic [LINE_W-1:0] node_line;
    logic [POS_W-1:0]  node_off;
    logic [POS_W-1:0]  node_end;
    logic [IND_W-1:0]  node_ind;
    logic              fin;
    status_t           st;
    logic [LINE_W-1:0] fin_line;
  } rec_t;

  function automatic lex_state_t lex_reset();
    lex_state_t r;
    r.mode       = MODE_NORMAL;
    r.quote_char = '0;
    r.esc        = 1'b0;
    r.pend       = PEND_NONE;
    r.paren      = '0;
    r.bracket    = '0;
    r.brace      = '0;
    r.line_cnt   = LINE_W'(1);
    r.node_line  = LINE_W'(1);
    r.node_off   = '0;
    r.indent     = '0;
    r.seen       = 1'b0;
    r.hash       = 1'b0;
    r.frozen     = 1'b0;
    return r;
  endfunction

  function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] v);
    return (v != LINE_TOP) ? v + LINE_W'(1) : LINE_TOP;
  endfunction

  function automatic logic [DEPTH_W-1:0] depth_up(input logic [DEPTH_W-1:0] v);
    return (v < DEPTH_TOP) ? v + DEPTH_W'(1) : DEPTH_TOP;
  endfunction

  function automatic logic [DEPTH_W-1:0] depth_down(input logic [DEPTH_W-1:0] v);
    return (v != '0) ? v - DEPTH_W'(1) : '0;
  endfunction

  function automatic lex_state_t feed_raw(input lex_state_t s, input logic [7:0] b);
    lex_state_t     r;
    logic [IND_W:0] sum;
    r   = s;
    sum = {1'b0, s.indent} + (IND_W+1)'(INDENT_TAB);
    if (!s.seen) begin
      if (b inside {CH_SP, CH_TAB, CH_CR, CH_LF}) begin
        if (!s.frozen) begin
          if (b == CH_TAB) begin
            r.indent = sum[IND_W] ? IND_TOP : sum[IND_W-1:0];
          end else if (b == CH_SP) begin
            r.indent = (s.indent != IND_TOP) ? s.indent + IND_W'(1) : IND_TOP;
          end else begin
            r.frozen = 1'b1;
          end
        end
      end else begin
        r.seen = 1'b1;
        r.hash = (b == CH_HASH);
      end
    end
    return r;
  endfunction

  function automatic lex_step_t newline_event(input lex_state_t s,
                                              input logic [POS_W-1:0] pos);
    lex_step_t r;
    logic      open;
    r.state  = s;
    r.node_v = 1'b0;
    open = (s.paren != '0) || (s.bracket != '0) || (s.brace != '0) ||
           (s.mode == MODE_QUOTE);
    if (!open && s.mode != MODE_BLOCK) begin
      r.node_v          = s.seen && !s.hash;
      r.state.node_off  = (pos < POS_TOP) ? pos + POS_W'(1) : POS_TOP;
      r.state.node_line = line_inc(s.line_cnt);
      r.state.indent    = '0;
      r.state.seen      = 1'b0;
      r.state.hash      = 1'b0;
      r.state.frozen    = 1'b0;
    end
    r.state.line_cnt = line_inc(s.line_cnt);
    return r;
  endfunction

  function automatic lex_step_t process_byte(input lex_state_t s, input logic [7:0] c,
                                             input logic [POS_W-1:0] pos);
    lex_step_t  r;
    lex_state_t n;
    n = s;
    case (s.mode)
      MODE_BLOCK: begin
        if (c == CH_STAR) n.pend = PEND_OPEN;
      end
      MODE_LINECMT: begin
        if (c == CH_LF) n.mode = MODE_NORMAL;
      end
      MODE_QUOTE: begin
        if (s.esc) begin
          n.esc = 1'b0;
        end else if (c == CH_BSL) begin
          n.esc = 1'b1;
        end else if (c == s.quote_char) begin
          n.mode       = MODE_NORMAL;
          n.quote_char = '0;
        end
      end
      default: begin
        case (c)
          CH_SLASH:     n.pend = PEND_OPEN;
          CH_HASH:      n.mode = MODE_LINECMT;
          CH_BSL:       n.pend = PEND_BSL;
          CH_DQ, CH_SQ: begin
            n.mode       = MODE_QUOTE;
            n.quote_char = c;
          end
          CH_LPAR:      n.paren   = depth_up(s.paren);
          CH_RPAR:      n.paren   = depth_down(s.paren);
          CH_LBRK:      n.bracket = depth_up(s.bracket);
          CH_RBRK:      n.bracket = depth_down(s.bracket);
          CH_LBRC:      n.brace   = depth_up(s.brace);
          CH_RBRC:      n.brace   = depth_down(s.brace);
          default:      n.mode    = s.mode;
        endcase
      end
    endcase
    if (c == CH_LF) begin
      r = newline_event(n, pos);
    end else begin
      r.state  = n;
      r.node_v = 1'b0;
    end
    return r;
  endfunction

  function automatic lex_step_t lex_byte(input lex_state_t s, input logic [7:0] b,
                                         input logic [POS_W-1:0] pos);
    lex_step_t  r;
    lex_state_t n;
    logic       done;
    n        = s;
    n.pend   = PEND_NONE;
    done     = 1'b0;
    r.state  = n;
    r.node_v = 1'b0;
    if (s.pend != PEND_NONE) begin
      if (s.mode == MODE_BLOCK) begin
        if (b == CH_SLASH) begin
          r.state.mode = MODE_NORMAL;
          done         = 1'b1;
        end
      end else if (s.mode == MODE_NORMAL) begin
        if (s.pend == PEND_OPEN && b == CH_STAR) begin
          r.state.mode = MODE_BLOCK;
          done         = 1'b1;
        end else if (s.pend == PEND_BSL && b == CH_CR) begin
          r.state.pend = PEND_BSLCR;
          done         = 1'b1;
        end else if ((s.pend == PEND_BSL || s.pend == PEND_BSLCR) && b == CH_LF) begin
          r.state.line_cnt = line_inc(s.line_cnt);
          done             = 1'b1;
        end
      end
    end
    if (!done) r = process_byte(n, b, pos);
    return r;
  endfunction

endpackage

// ===== rtl/lls_front.sv =====
// Front end: lexer state, per-byte classification and result record build.
`timescale 1ns / 1ps
module lls_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             rec_v,
  output lls_pkg::rec_t    rec
);

  lls_pkg::lex_state_t            state_r;
  lls_pkg::lex_state_t            state_nxt;
  logic [lls_pkg::POS_W-1:0]      pos_r;
  logic [lls_pkg::POS_W-1:0]      pos_nxt;
  lls_pkg::lex_state_t            fed;
  lls_pkg::lex_step_t             step;
  lls_pkg::lex_state_t            post;
  logic [lls_pkg::POS_W-1:0]      pos_inc;
  logic                           closed;
  logic                           imp_v;
  lls_pkg::status_t               st;

  always_comb begin
    fed     = lls_pkg::feed_raw(state_r, in_byte);
    step    = lls_pkg::lex_byte(fed, in_byte, pos_r);
    post    = step.state;
    pos_inc = (pos_r < lls_pkg::POS_TOP) ? pos_r + lls_pkg::POS_W'(1) : pos_r;

    closed = (post.paren == '0) && (post.bracket == '0) && (post.brace == '0) &&
             (post.mode != lls_pkg::MODE_QUOTE) && (post.mode != lls_pkg::MODE_BLOCK);
    imp_v  = closed && post.seen && !post.hash;

    if (post.mode == lls_pkg::MODE_QUOTE) begin
      st = lls_pkg::ST_QUOTE;
    end else if (post.paren != '0) begin
      st = lls_pkg::ST_PAREN;
    end else if (post.bracket != '0) begin
      st = lls_pkg::ST_BRACKET;
    end else if (post.brace != '0) begin
      st = lls_pkg::ST_BRACE;
    end else if (post.mode == lls_pkg::MODE_BLOCK) begin
      st = lls_pkg::ST_BLOCK;
    end else begin
      st = lls_pkg::ST_OK;
    end

    rec.fin      = in_last;
    rec.st       = st;
    rec.fin_line = closed ? lls_pkg::line_inc(post.line_cnt) : post.node_line;
    if (step.node_v) begin
      rec.node_v    = 1'b1;
      rec.node_line = fed.node_line;
      rec.node_off  = fed.node_off;
      rec.node_end  = pos_r;
      rec.node_ind  = fed.indent;
    end else begin
      rec.node_v    = in_last && imp_v;
      rec.node_line = post.node_line;
      rec.node_off  = post.node_off;
      rec.node_end  = pos_inc;
      rec.node_ind  = post.indent;
    end
    rec_v = step.node_v || in_last;

    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (fire) begin
      state_nxt = in_last ? lls_pkg::lex_reset() : post;
      pos_nxt   = in_last ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lls_pkg::lex_reset();
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_last |=> pos_r == '0 && state_r.line_cnt == lls_pkg::LINE_W'(1))
    else $error("source position not restarted after last byte");

  a_pend_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == lls_pkg::MODE_LINECMT || state_r.mode == lls_pkg::MODE_QUOTE)
      |-> state_r.pend == lls_pkg::PEND_NONE)
    else $error("lookahead pending inside comment or quote");

  a_node_span: assert property (@(posedge clk) disable iff (!rst_n)
    fire && rec_v && rec.node_v |-> rec.node_end >= rec.node_off)
    else $error("node ends before it starts");

endmodule

// ===== rtl/lls_queue.sv =====
// Short record queue between the lexer front end and the output back end.
`timescale 1ns / 1ps
module lls_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lls_pkg::rec_t push_rec,
  input  logic          pop,
  output lls_pkg::rec_t head,
  output logic          empty,
  output logic          full
);

  lls_pkg::rec_t              mem_r [lls_pkg::Q_DEPTH];
  logic [lls_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [lls_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [lls_pkg::Q_AW:0]     count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (lls_pkg::Q_AW+1)'(lls_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + lls_pkg::Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + lls_pkg::Q_AW'(1);
      if (push && !pop) begin
        count_r <= count_r + (lls_pkg::Q_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (lls_pkg::Q_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("push into full queue");

endmodule

// ===== rtl/lls_back.sv =====
// Back end: expand records into node and status transactions on the output register.
`timescale 1ns / 1ps
module lls_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lls_pkg::rec_t                head,
  input  logic                         empty,
  output logic                         pop,
  output logic [lls_pkg::TDATA_W-1:0]  out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready
);

  logic                          valid_r;
  logic                          phase_r;
  logic                          phase_nxt;
  logic [lls_pkg::TDATA_W-1:0]   tdata_r;
  logic [lls_pkg::TDATA_W-1:0]   tdata_nxt;
  logic                          kind_r;
  logic                          kind_nxt;
  logic                          fin_r;
  logic                          fin_nxt;
  logic                          can_load;
  logic                          load;
  logic                          emit_node;
  logic                          rec_done;
  logic [lls_pkg::OFF_W-1:0]     off;
  logic [lls_pkg::LEN_W-1:0]     len;

  always_comb begin
    can_load  = !valid_r || out_tready;
    load      = can_load && !empty;
    emit_node = head.node_v && !phase_r;
    rec_done  = !(emit_node && head.fin);
    pop       = load && rec_done;
    phase_nxt = phase_r;
    if (load) phase_nxt = !rec_done;

    off = (head.node_off > {1'b0, lls_pkg::OFF_TOP}) ? lls_pkg::OFF_TOP
                                                     : head.node_off[lls_pkg::OFF_W-1:0];
    len = lls_pkg::LEN_W'(head.node_end - head.node_off);

    if (emit_node) begin
      kind_nxt  = 1'b0;
      fin_nxt   = 1'b0;
      tdata_nxt = {3'b000, lls_pkg::ST_OK, head.node_ind, len, off, head.node_line};
    end else begin
      kind_nxt  = 1'b1;
      fin_nxt   = 1'b1;
      tdata_nxt = {3'b000, head.st, lls_pkg::IND_W'(0), lls_pkg::LEN_W'(0),
                   lls_pkg::OFF_W'(0), head.fin_line};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= tdata_nxt;
      kind_r  <= kind_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign out_tdata  = tdata_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = fin_r;
  assign out_tvalid = valid_r;

  a_phase_fin: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !empty && head.fin && head.node_v)
    else $error("split record lost its status half");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    load && !emit_node |-> pop)
    else $error("status transaction did not retire its record");

endmodule

// ===== rtl/logical_line_scanner.sv =====
// Top level of the logical line scanner.
`timescale 1ns / 1ps
// Splits a byte stream into logical lines, following comments, quoted strings,
// line continuations and bracket nesting. One source byte is accepted per clock
// while the four-record queue between the lexer and the output stage has room;
// the lexer state is registered per accepted byte. Each logical line that
// is not blank and not a comment leaves as one node transaction (tuser 0), and the
// byte marked tlast is followed by a status transaction (tuser 1, tlast 1). A last
// byte that also completes a line produces two transactions, the node transaction
// first, then the status one. Records pass through the queue and output register;
// the scanner restarts from line 1, offset 0 on the byte after a last byte.
module logical_line_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  // [7:0] byte_req
  input  logic [7:0]                   in_tdata,
  input  logic                         in_tlast,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [24:0] line, [48:25] start_offset, [73:49] length, [89:74] indent,
  // [92:90] status, [95:93] zero
  output logic [lls_pkg::TDATA_W-1:0]  out_tdata,
  // [0] kind
  output logic                         out_tuser,
  output logic                         out_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready
);

  logic          fire;
  logic          rec_v;
  lls_pkg::rec_t rec;
  lls_pkg::rec_t head;
  logic          q_empty;
  logic          q_full;
  logic          q_pop;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  lls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .rec_v   (rec_v),
    .rec     (rec)
  );

  lls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire && rec_v),
    .push_rec (rec),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  lls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule
